// File: hdl/cpc_pkg.sv
// Shared types, widths and the arctangent table for the cartesian/polar converter.
// No dependencies; imported by cpc_gain and cartesian_polar_converter_unit.
`default_nettype none
package cpc_pkg;

  localparam int unsigned ITERATIONS   = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned NITER = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned XW        = 34;  // datapath coordinate width
  localparam int unsigned ZW        = 34;  // angle accumulator width, 2^31 = pi
  localparam int unsigned KW        = 33;  // signed width of the inverse gain
  localparam int unsigned PW        = XW + KW;
  localparam int unsigned RSHIFT    = 46;
  localparam int unsigned RW        = PW - RSHIFT;

  localparam logic signed [KW-1:0] INV_GAIN  = 33'sd2608131496;
  localparam logic signed [ZW-1:0] ANGLE_PI  = 34'sd2147483648;
  localparam int                   LIMIT_MAG = 46341;

  localparam logic OP_TO_POLAR = 1'b0;
  localparam logic OP_TO_CART  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cpc_stage_t;

  typedef struct packed {
    logic [15:0]        mag;
    logic signed [15:0] ang;
    logic signed [16:0] re;
    logic signed [16:0] im;
  } cpc_res_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 34'sd536870912;
      1:       v = 34'sd316933406;
      2:       v = 34'sd167458907;
      3:       v = 34'sd85004756;
      4:       v = 34'sd42667331;
      5:       v = 34'sd21354465;
      6:       v = 34'sd10679838;
      7:       v = 34'sd5340245;
      8:       v = 34'sd2670163;
      9:       v = 34'sd1335087;
      10:      v = 34'sd667544;
      11:      v = 34'sd333772;
      12:      v = 34'sd166886;
      13:      v = 34'sd83443;
      14:      v = 34'sd41722;
      15:      v = 34'sd20861;
      16:      v = 34'sd10430;
      17:      v = 34'sd5215;
      18:      v = 34'sd2608;
      19:      v = 34'sd1304;
      20:      v = 34'sd652;
      21:      v = 34'sd326;
      22:      v = 34'sd163;
      23:      v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/cpc_gain.sv
// Gain removal, rounding, saturation and result packing: two register stages.
// Depends on cpc_pkg.
`default_nettype none
module cpc_gain
  import cpc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire cpc_stage_t in_stage_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cpc_res_t        out_res_o
);

  localparam logic signed [RW-1:0] LIM_POS = RW'(LIMIT_MAG);
  localparam logic signed [RW-1:0] LIM_NEG = -RW'(LIMIT_MAG);
  localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (RSHIFT - 1);

  // multiply stage
  logic                 va_q;
  logic                 op_a_q, zero_a_q;
  logic signed [PW-1:0] px_a_q, py_a_q;
  logic signed [15:0]   ang_a_q;
  logic                 en_a;

  // output stage
  logic     vb_q;
  cpc_res_t res_b_q, res_b_d;
  logic     en_b;

  logic signed [ZW-1:0] z_rnd;
  logic signed [PW-1:0] sx, sy;
  logic signed [RW-1:0] rx, ry;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  assign z_rnd = in_stage_i.z + ZW'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      op_a_q   <= in_stage_i.op;
      zero_a_q <= in_stage_i.zero;
      px_a_q   <= in_stage_i.x * INV_GAIN;
      py_a_q   <= in_stage_i.y * INV_GAIN;
      ang_a_q  <= z_rnd[31:16];
    end
  end

  assign sx = px_a_q + HALF;
  assign sy = py_a_q + HALF;
  assign rx = sx[PW-1:RSHIFT];
  assign ry = sy[PW-1:RSHIFT];

  always_comb begin
    res_b_d = '0;
    if (op_a_q == OP_TO_POLAR) begin
      if (!zero_a_q) begin
        if (rx < 0)            res_b_d.mag = '0;
        else if (rx > LIM_POS) res_b_d.mag = 16'(LIMIT_MAG);
        else                   res_b_d.mag = rx[15:0];
        res_b_d.ang = ang_a_q;
      end
    end else begin
      if (rx > LIM_POS)      res_b_d.re = LIM_POS[16:0];
      else if (rx < LIM_NEG) res_b_d.re = LIM_NEG[16:0];
      else                   res_b_d.re = rx[16:0];
      if (ry > LIM_POS)      res_b_d.im = LIM_POS[16:0];
      else if (ry < LIM_NEG) res_b_d.im = LIM_NEG[16:0];
      else                   res_b_d.im = ry[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      res_b_q <= res_b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_res_o   = res_b_q;

endmodule
`default_nettype wire

// File: hdl/cartesian_polar_converter_unit.sv
// Cartesian/polar converter: unrolled CORDIC, one register stage per iteration.
// From input accept to result valid an item passes through one pre-rotation stage,
// NITER iteration stages, a multiply stage and an output stage.
// Throughput: one item per cycle; a full stage holds while the stage after it is held.
// Reset: asynchronous, active low, clears all stage valid bits; no clearing pass.
// Depends on cpc_pkg and cpc_gain.
`default_nettype none
module cartesian_polar_converter_unit
  import cpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // in_real, in_imag, in_magnitude, in_angle
  input  wire logic        s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata   // out_magnitude, out_angle, out_real, out_imag, pad
);

  cpc_stage_t st_q   [0:NITER];
  cpc_stage_t st_d   [0:NITER];
  logic       vld_q  [0:NITER];
  logic       en     [0:NITER];
  logic       gain_rdy;
  cpc_res_t   res;

  logic signed [15:0] in_re, in_im, in_ang;
  logic        [15:0] in_mag;

  assign in_re  = s_axis_tdata[15:0];
  assign in_im  = s_axis_tdata[31:16];
  assign in_mag = s_axis_tdata[47:32];
  assign in_ang = s_axis_tdata[63:48];

  // pre-rotation into the right half plane
  always_comb begin
    st_d[0]      = '0;
    st_d[0].op   = s_axis_tuser;
    if (s_axis_tuser == OP_TO_POLAR) begin
      st_d[0].zero = (in_re == '0) && (in_im == '0);
      st_d[0].x    = {{(XW-16-FRAC_BITS){in_re[15]}}, in_re, {FRAC_BITS{1'b0}}};
      st_d[0].y    = {{(XW-16-FRAC_BITS){in_im[15]}}, in_im, {FRAC_BITS{1'b0}}};
      if (in_re[15]) begin
        st_d[0].x = -st_d[0].x;
        st_d[0].y = -st_d[0].y;
        st_d[0].z = ANGLE_PI;
      end
    end else begin
      st_d[0].x = {{(XW-16-FRAC_BITS){1'b0}}, in_mag, {FRAC_BITS{1'b0}}};
      st_d[0].z = {{(ZW-32){in_ang[15]}}, in_ang, 16'h0000};
      if (in_ang > 16'sd16384) begin
        st_d[0].z = st_d[0].z - ANGLE_PI;
        st_d[0].x = -st_d[0].x;
      end else if (in_ang < -16'sd16384) begin
        st_d[0].z = st_d[0].z + ANGLE_PI;
        st_d[0].x = -st_d[0].x;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < NITER; i++) begin : g_iter
      logic signed [XW-1:0] xs, ys;
      logic                 up;
      assign xs = st_q[i].x >>> i;
      assign ys = st_q[i].y >>> i;
      // turn towards the real axis when vectoring, towards zero residual angle when rotating
      assign up = (st_q[i].op == OP_TO_POLAR) ? !st_q[i].y[XW-1] : st_q[i].z[ZW-1];

      always_comb begin
        st_d[i+1] = st_q[i];
        if (up) begin
          st_d[i+1].x = st_q[i].x + ys;
          st_d[i+1].y = st_q[i].y - xs;
        end else begin
          st_d[i+1].x = st_q[i].x - ys;
          st_d[i+1].y = st_q[i].y + xs;
        end
        // the angle moves with the turn in both directions
        if (up) begin
          st_d[i+1].z = st_q[i].z + atan_lut(i);
        end else begin
          st_d[i+1].z = st_q[i].z - atan_lut(i);
        end
      end

      assign en[i] = !vld_q[i] || en[i+1];
    end
  endgenerate

  assign en[NITER]     = !vld_q[NITER] || gain_rdy;
  assign s_axis_tready = en[0];

  generate
    for (i = 0; i <= NITER; i++) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[i] <= 1'b0;
        end else if (en[i]) begin
          vld_q[i] <= (i == 0) ? s_axis_tvalid : vld_q[(i == 0) ? 0 : i-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[i]) begin
          st_q[i] <= st_d[i];
        end
      end
    end
  endgenerate

  cpc_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[NITER]),
    .in_ready_o  (gain_rdy),
    .in_stage_i  (st_q[NITER]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {6'b0, res.im, res.re, res.ang, res.mag};

  // a free output always lets the input side take an item
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is free");

  // polar and cartesian results never both carry data
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.mag != '0 || res.ang != '0) |-> res.re == '0 && res.im == '0)
    else $error("polar and cartesian fields both set");

  a_mag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.mag <= 16'(LIMIT_MAG))
    else $error("magnitude beyond saturation limit");

  a_cart_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.re <= 17'sd46341 && res.re >= -17'sd46341
                   && res.im <= 17'sd46341 && res.im >= -17'sd46341)
    else $error("cartesian result beyond saturation limit");

endmodule
`default_nettype wire

// File: tb/tb_cartesian_polar_converter_unit.sv
// Self-checking testbench for cartesian_polar_converter_unit: a table of directed items,
// then random items in both directions, checked against a CORDIC predictor kept here.
// Depends on cpc_pkg and the converter RTL only.
`default_nettype none
module tb_cartesian_polar_converter_unit;

  localparam int unsigned STEPS      = (cpc_pkg::ITERATIONS > 24) ? 24 : cpc_pkg::ITERATIONS;
  localparam int          N_RANDOM   = 500;
  localparam int          QUIET_TAIL = 60;    // items at the end sent with no idling
  localparam int          HOLD_LEN   = 200;   // long receiver hold-off, in cycles
  localparam int          DRAIN_WAIT = 40;    // wait after the queue empties, in cycles
  localparam int          STALL_MAX  = 4000;

  localparam longint ANGLE_PI   = 64'sd2147483648;
  localparam longint ANGLE_HALF = 64'sd1073741824;
  localparam longint GAIN_RECIP = 64'sd2608131496;
  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic               op;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [15:0]        mag;
    logic signed [15:0] ang;
  } sample_t;

  typedef struct packed {
    bit                 fixed;  // result typed in below
    sample_t            s;
    cpc_pkg::cpc_res_t  want;
  } stim_row_t;

  localparam int N_DIRECTED = 23;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, '{cpc_pkg::OP_TO_POLAR, 16'h0000, 16'h0000, 16'hffff, 16'h7fff}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h7fff, 16'h0000, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h0000, 16'h7fff, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h0000, 16'h8000, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h8000, 16'h8000, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h8000, 16'h7fff, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'hffff, 16'h0000, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'h0001, 16'hffff, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_POLAR, 16'hffff, 16'hffff, 16'h0000, 16'h0000}, '0},
    '{1'b1, '{cpc_pkg::OP_TO_CART,  16'hffff, 16'hffff, 16'h0000, 16'h8000}, '0},
    '{1'b1, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'h0000, 16'h7fff}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'h4000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'h4001}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'hc000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'hbfff}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'h8000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hffff, 16'h2000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hffff, 16'h0000}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'h0001, 16'h7fff}, '0},
    '{1'b0, '{cpc_pkg::OP_TO_CART,  16'h0000, 16'h0000, 16'hb505, 16'h6000}, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // in_real, in_imag, in_magnitude, in_angle
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // out_magnitude, out_angle, out_real, out_imag, pad

  cpc_pkg::cpc_res_t expected_q [$];
  int  items_sent;
  int  results_seen;
  int  err_count;
  int  stuck_cycles;
  int  idle_odds;       // 1 in idle_odds chance of a burst, 0 for none
  bit  hold_req;
  bit  hold_seen;

  cartesian_polar_converter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint unscale(input longint v);
    return (v * GAIN_RECIP + (64'sd1 <<< 45)) >>> 46;
  endfunction

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Unrolled CORDIC, vectoring for cartesian to polar, rotation for the reverse.
  function automatic cpc_pkg::cpc_res_t convert_expected(input sample_t s);
    cpc_pkg::cpc_res_t r;
    longint x, y, z, nx, t;
    r = '0;
    if (s.op == cpc_pkg::OP_TO_POLAR) begin
      x = longint'(s.re) * 16384;
      y = longint'(s.im) * 16384;
      if (x == 0 && y == 0) return r;
      z = 0;
      // left half plane: turn by pi first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = ANGLE_PI;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ATAN_STEP[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ATAN_STEP[i];
        end
        x = nx;
      end
      t = limit(unscale(x), 0, cpc_pkg::LIMIT_MAG);
      r.mag = t[15:0];
      t = (z + 32768) >>> 16;
      r.ang = t[15:0];
    end else begin
      x = longint'(s.mag) * 16384;
      y = 0;
      z = longint'(s.ang) * 65536;
      // fold rear half angles with the start vector negated
      if (z > ANGLE_HALF) begin
        z = z - ANGLE_PI;
        x = -x;
      end else if (z < -ANGLE_HALF) begin
        z = z + ANGLE_PI;
        x = -x;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - ATAN_STEP[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + ATAN_STEP[i];
        end
        x = nx;
      end
      t = limit(unscale(x), -cpc_pkg::LIMIT_MAG, cpc_pkg::LIMIT_MAG);
      r.re = t[16:0];
      t = limit(unscale(y), -cpc_pkg::LIMIT_MAG, cpc_pkg::LIMIT_MAG);
      r.im = t[16:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_coord();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      6, 7:    v = 16'($urandom_range(0, 64) - 32);
      8:       v = 16'h0000;
      9:       v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    s.op  = 1'($urandom_range(0, 1));
    s.re  = pick_coord();
    s.im  = pick_coord();
    // magnitudes above the nominal range still exercise saturation
    s.mag = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, cpc_pkg::LIMIT_MAG));
    s.ang = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 3) * 16384
                                              + $urandom_range(0, 2) - 1)
                                         : 16'($urandom);
    return s;
  endfunction

  // Offer one item, after an optional idle burst, from the falling edge on and hold it until taken.
  task automatic offer(input sample_t s, input bit fixed, input cpc_pkg::cpc_res_t want);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tdata  = {s.ang, s.mag, s.im, s.re};
    s_axis_tuser  = s.op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(fixed ? want : convert_expected(s));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_result(input cpc_pkg::cpc_res_t got, input cpc_pkg::cpc_res_t want);
    if (got.mag !== want.mag) begin
      $error("out_magnitude: expected %0d, got %0d", want.mag, got.mag);
      err_count++;
    end
    if (got.ang !== want.ang) begin
      $error("out_angle: expected %0d, got %0d", want.ang, got.ang);
      err_count++;
    end
    if (got.re !== want.re) begin
      $error("out_real: expected %0d, got %0d", want.re, got.re);
      err_count++;
    end
    if (got.im !== want.im) begin
      $error("out_imag: expected %0d, got %0d", want.im, got.im);
      err_count++;
    end
  endtask

  // Compare each accepted result with the oldest one waiting.
  always @(posedge clk_i) begin
    cpc_pkg::cpc_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mag = m_axis_tdata[15:0];
      got.ang = m_axis_tdata[31:16];
      got.re  = m_axis_tdata[48:32];
      got.im  = m_axis_tdata[65:49];
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: mag %0d ang %0d re %0d im %0d",
               got.mag, got.ang, got.re, got.im);
        err_count++;
      end else begin
        check_result(got, expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_MAX) begin
      $display("cartesian_polar_converter_unit regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
        hold_req  = 1'b0;
        hold_seen = 1'b1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin
    sample_t s;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    err_count     = 0;
    stuck_cycles  = 0;
    idle_odds     = 4;
    hold_req      = 1'b0;
    hold_seen     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < N_DIRECTED; k++) begin
      offer(DIRECTED[k].s, DIRECTED[k].fixed, DIRECTED[k].want);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      // vary the idling every 80 items, including stretches with none
      if (k % 80 == 0) idle_odds = (k >= N_RANDOM - QUIET_TAIL) ? 0 : $urandom_range(0, 4) * 3;
      if (k >= N_RANDOM - QUIET_TAIL) idle_odds = 0;
      if (k == 150) hold_req = 1'b1;
      s = pick_sample();
      offer(s, 1'b0, '0);
    end
    s_axis_tvalid = 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d items sent (%0d from the table), %0d results checked, %0d mismatches",
             items_sent, N_DIRECTED, results_seen, err_count);
    $display("both directions, axis and saturation cases, long output hold-off %s",
             hold_seen ? "done" : "missed");
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("cartesian_polar_converter_unit regression: pass");
    end else begin
      $display("cartesian_polar_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
